// File: hw/rtl/mfhp_pkg.sv
// Shared types, constants and layout helpers for the MAC frame header parser.
package mfhp_pkg;

    localparam int PAYLOAD_MAX_DEF = 127;
    localparam int FRAME_MAX_DEF   = 127;

    localparam logic [15:0] PAN_NONE     = 16'hFFFF;
    localparam logic [7:0]  MESH_LO      = 8'h40;
    localparam logic [7:0]  MESH_HI      = 8'h7F;
    localparam logic [7:0]  NIBBLE_MASK  = 8'h0F;
    localparam logic [7:0]  PROFILE_1    = 8'h01;
    localparam logic [7:0]  PROFILE_2    = 8'h02;
    localparam logic [6:0]  COUNT_SAT    = 7'h7F;
    localparam logic [6:0]  MIN_FRAME    = 7'd2;
    localparam logic [6:0]  BEACON_PROBE = 7'd6;
    localparam logic [6:0]  PROBE_K0     = 7'd0;
    localparam logic [6:0]  PROBE_K4     = 7'd4;
    localparam logic [6:0]  PROBE_K5     = 7'd5;
    localparam logic [6:0]  POS_CTRL_LO  = 7'd0;
    localparam logic [6:0]  POS_CTRL_HI  = 7'd1;
    localparam logic [4:0]  SEQ_OFF      = 5'd2;

    localparam logic [2:0] FT_BEACON = 3'd0;
    localparam logic [2:0] FT_DATA   = 3'd1;
    localparam logic [2:0] FT_CMD    = 3'd3;

    localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
    localparam logic [1:0] CLASS_BEACON  = 2'd1;
    localparam logic [1:0] CLASS_MESH    = 2'd2;

    localparam logic [1:0] MODE_SHORT = 2'd2;
    localparam logic [1:0] MODE_EXT   = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [4:0] seq_end;
        logic [4:0] dadr_off;
        logic [4:0] span_off;
        logic [4:0] sadr_off;
        logic [4:0] hdr_len;
    } layout_t;

    typedef struct packed {
        logic [15:0] ctrl;
        logic [7:0]  seq;
        logic [15:0] dpan;
        logic [15:0] span;
        logic [63:0] daddr;
        logic [63:0] saddr;
        logic [6:0]  pos;
        logic [6:0]  pcount;
        logic [7:0]  probe0;
        logic [7:0]  probe4;
        logic [7:0]  probe5;
    } frame_t;

    localparam frame_t FRAME_CLEAR = '{
        ctrl: 16'h0000, seq: 8'h00, dpan: PAN_NONE, span: PAN_NONE,
        daddr: 64'h0, saddr: 64'h0, pos: 7'd0, pcount: 7'd0,
        probe0: 8'h00, probe4: 8'h00, probe5: 8'h00
    };

    typedef struct packed {
        logic        parse_ok;
        logic [2:0]  ftype;
        logic [1:0]  fversion;
        logic [7:0]  seq_number;
        logic [15:0] dest_pan;
        logic [15:0] source_pan;
        logic [63:0] dest_address;
        logic [63:0] source_address;
        logic [3:0]  address_modes;
        logic [5:0]  header_flags;
        logic [1:0]  protocol_class;
        logic [6:0]  payload_length;
    } result_t;

    function automatic logic [4:0] addr_len(logic [1:0] mode);
        logic [4:0] len;
        case (mode)
            MODE_SHORT: len = 5'd2;
            MODE_EXT:   len = 5'd8;
            default:    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic layout_t make_layout(logic [15:0] fcf);
        layout_t    l;
        logic [1:0] dmode;
        logic [1:0] smode;
        logic       comp;
        logic       supp;
        dmode      = fcf[11:10];
        smode      = fcf[15:14];
        comp       = fcf[6];
        supp       = fcf[8];
        l.seq_end  = SEQ_OFF + (supp ? 5'd0 : 5'd1);
        l.dadr_off = l.seq_end + (dmode[1] ? 5'd2 : 5'd0);
        l.span_off = l.dadr_off + addr_len(dmode);
        l.sadr_off = l.span_off + ((smode[1] && !comp) ? 5'd2 : 5'd0);
        l.hdr_len  = l.sadr_off + addr_len(smode);
        return l;
    endfunction

endpackage

// File: hw/rtl/mac_frame_header_parser.sv
// Top level of the MAC frame header parser.
// Feed one frame byte per transaction, frame control low byte first, with s_tlast on the final
// byte; one byte is taken every cycle unless a final byte is held. Each last byte yields one
// result transaction via the input register and then the result register; parse_ok travels
// in m_tuser and a failed parse gives all-zero m_tdata. Non-final bytes are never held back
// by the output side; a final byte waits in the input register only while a previous result
// is still untaken. Bytes past FRAME_MAX are dropped, though their last mark still ends the frame.
module mac_frame_header_parser
    import mfhp_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF,
    parameter int FRAME_MAX   = FRAME_MAX_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // frame_byte[7:0]
    input  logic         s_tlast,   // frame_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // ftype[2:0], fversion[4:3], seq_number[12:5], dest_pan[28:13],
    // source_pan[44:29], dest_address[108:45], source_address[172:109],
    // address_modes[176:173], header_flags[182:177], protocol_class[184:183],
    // payload_length[191:185]
    output logic [191:0] m_tdata,
    output logic         m_tuser    // parse_ok
);

    byte_item_t item;
    logic       item_valid;
    logic       advance;
    logic       load;
    frame_t     frame_done;
    result_t    result_comb;
    result_t    result_q;

    assign advance = item_valid && (!item.last || !m_tvalid || m_tready);
    assign load    = advance && item.last;

    mfhp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mfhp_frame_state #(
        .FRAME_MAX (FRAME_MAX)
    ) u_frame_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .frame_done (frame_done)
    );

    mfhp_result #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_result (
        .frame  (frame_done),
        .result (result_comb)
    );

    mfhp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .result_in  (result_comb),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result_out (result_q)
    );

    assign m_tuser = result_q.parse_ok;
    assign m_tdata = {result_q.payload_length, result_q.protocol_class,
                      result_q.header_flags, result_q.address_modes,
                      result_q.source_address, result_q.dest_address,
                      result_q.source_pan, result_q.dest_pan,
                      result_q.seq_number, result_q.fversion,
                      result_q.ftype};

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed parse carries nonzero header fields");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> item_valid && item.last && m_tvalid && !m_tready)
        else $error("input stalled without a blocked final byte");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(load))
        else $error("result transaction without a final byte");

    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[184:183] != 2'd3)
        else $error("invalid protocol class");

endmodule

// File: hw/rtl/mfhp_in_stage.sv
// Input register stage holding one frame byte transaction.
module mfhp_in_stage
    import mfhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // frame_byte[7:0]
    input  logic       s_tlast,
    input  logic       advance,
    output logic       item_valid,
    output byte_item_t item
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= '{data: s_tdata, last: s_tlast};
        end
    end

endmodule

// File: hw/rtl/mfhp_frame_state.sv
// Per-frame header state: places each byte by its position and the frame control layout.
module mfhp_frame_state
    import mfhp_pkg::*;
#(
    parameter int FRAME_MAX = FRAME_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  byte_item_t item,
    output frame_t     frame_done
);

    localparam logic [6:0] FRAME_LIMIT = 7'(FRAME_MAX);

    frame_t     frame_reg;
    frame_t     frame_next;
    frame_t     absorbed;
    layout_t    lay;
    logic [6:0] pos;
    logic [6:0] dk_dpan;
    logic [6:0] dk_daddr;
    logic [6:0] dk_span;
    logic [6:0] dk_saddr;
    logic [6:0] dk_pay;

    assign lay        = make_layout(frame_reg.ctrl);
    assign pos        = frame_reg.pos;
    assign dk_dpan    = pos - {2'b00, lay.seq_end};
    assign dk_daddr   = pos - {2'b00, lay.dadr_off};
    assign dk_span    = pos - {2'b00, lay.span_off};
    assign dk_saddr   = pos - {2'b00, lay.sadr_off};
    assign dk_pay     = pos - {2'b00, lay.hdr_len};
    assign frame_done = absorbed;

    always_comb
    begin
        absorbed = frame_reg;
        if (pos < FRAME_LIMIT)
        begin
            absorbed.pos = pos + 7'd1;
            if (pos == POS_CTRL_LO)
            begin
                absorbed.ctrl[7:0] = item.data;
            end
            else if (pos == POS_CTRL_HI)
            begin
                absorbed.ctrl[15:8] = item.data;
            end
            else if (pos < {2'b00, lay.seq_end})
            begin
                absorbed.seq = item.data;
            end
            else if (pos < {2'b00, lay.dadr_off})
            begin
                absorbed.dpan[{dk_dpan[0], 3'b000} +: 8] = item.data;
            end
            else if (pos < {2'b00, lay.span_off})
            begin
                absorbed.daddr[{dk_daddr[2:0], 3'b000} +: 8] = item.data;
            end
            else if (pos < {2'b00, lay.sadr_off})
            begin
                absorbed.span[{dk_span[0], 3'b000} +: 8] = item.data;
            end
            else if (pos < {2'b00, lay.hdr_len})
            begin
                absorbed.saddr[{dk_saddr[2:0], 3'b000} +: 8] = item.data;
            end
            else
            begin
                if (dk_pay == PROBE_K0)
                begin
                    absorbed.probe0 = item.data;
                end
                else if (dk_pay == PROBE_K4)
                begin
                    absorbed.probe4 = item.data;
                end
                else if (dk_pay == PROBE_K5)
                begin
                    absorbed.probe5 = item.data;
                end
                if (frame_reg.pcount < COUNT_SAT)
                begin
                    absorbed.pcount = frame_reg.pcount + 7'd1;
                end
            end
        end
    end

    always_comb
    begin
        frame_next = frame_reg;
        if (advance)
        begin
            frame_next = item.last ? FRAME_CLEAR : absorbed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= FRAME_CLEAR;
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

endmodule

// File: hw/rtl/mfhp_result.sv
// Result decode: header checks, flags, payload length cap and protocol class.
module mfhp_result
    import mfhp_pkg::*;
#(
    parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
)
(
    input  frame_t  frame,
    output result_t result
);

    localparam logic [6:0] PAYLOAD_CAP = 7'(PAYLOAD_MAX);

    layout_t     lay;
    logic        ok;
    logic [2:0]  ft;
    logic [1:0]  smode;
    logic [15:0] span;
    logic [6:0]  plen;
    logic [7:0]  profile;
    logic [1:0]  cls;

    assign lay     = make_layout(frame.ctrl);
    assign ok      = (frame.pos >= MIN_FRAME) && (frame.pos >= {2'b00, lay.hdr_len});
    assign ft      = frame.ctrl[2:0];
    assign smode   = frame.ctrl[15:14];
    assign span    = (smode[1] && frame.ctrl[6]) ? frame.dpan : frame.span;
    assign plen    = (frame.pcount > PAYLOAD_CAP) ? PAYLOAD_CAP : frame.pcount;
    assign profile = frame.probe5 & NIBBLE_MASK;

    always_comb
    begin
        cls = CLASS_UNKNOWN;
        if (ft == FT_BEACON && plen >= BEACON_PROBE && frame.probe4 == 8'h00
            && (profile == PROFILE_1 || profile == PROFILE_2))
        begin
            cls = CLASS_BEACON;
        end
        else if (ft == FT_DATA && plen != 7'd0
                 && frame.probe0 >= MESH_LO && frame.probe0 <= MESH_HI)
        begin
            cls = CLASS_MESH;
        end
        else if (ft == FT_CMD && plen != 7'd0
                 && (span == PAN_NONE || frame.dpan == PAN_NONE))
        begin
            cls = CLASS_MESH;
        end
    end

    always_comb
    begin
        result = '0;
        if (ok)
        begin
            result.parse_ok       = 1'b1;
            result.ftype          = ft;
            result.fversion       = frame.ctrl[13:12];
            result.seq_number     = frame.seq;
            result.dest_pan       = frame.dpan;
            result.source_pan     = span;
            result.dest_address   = frame.daddr;
            result.source_address = frame.saddr;
            result.address_modes  = {smode, frame.ctrl[11:10]};
            result.header_flags   = {frame.ctrl[9], frame.ctrl[8], frame.ctrl[6],
                                     frame.ctrl[4], frame.ctrl[5], frame.ctrl[3]};
            result.protocol_class = cls;
            result.payload_length = plen;
        end
    end

endmodule

// File: hw/rtl/mfhp_out_stage.sv
// Result register holding one decoded header transaction until it is taken.
module mfhp_out_stage
    import mfhp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    m_tready,
    output logic    m_tvalid,
    output result_t result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign m_tvalid   = valid_reg;
    assign result_out = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule
